FILE: design/mtq_pkg.sv
package mtq_pkg;

  localparam int IN_W  = 16;
  localparam int MAG_W = 15;

  typedef logic signed [IN_W-1:0] entry_t;
  typedef logic [MAG_W-1:0]       mag_t;
  typedef logic signed [IN_W-1:0] comp_t;

  localparam mag_t MAG_MAX = '1;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic neg_z;
  } sign_t;

endpackage

FILE: design/mtq_sqrt_lane.sv
module mtq_sqrt_lane
  import mtq_pkg::*;
#(
  parameter int RAD_W = 46
) (
  input  logic                   clk,
  input  logic [RAD_W/2-1:0]     en,
  input  logic [RAD_W-1:0]       rad,
  output mag_t                   mag
);

  localparam int RW = RAD_W / 2;

  logic [RAD_W-1:0] rad_r  [RW-1];
  logic [RW+1:0]    rem_r  [RW];
  logic [RW-1:0]    root_r [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [RAD_W-1:0] rad_in;
    logic [RW+1:0]    rem_in;
    logic [RW-1:0]    root_in;
    logic [RW+1:0]    rem_sh;
    logic [RW+1:0]    trial;

    if (i == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    assign rem_sh = {rem_in[RW-1:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en[i]) begin
        if (rem_sh >= trial) begin
          rem_r[i]  <= rem_sh - trial;
          root_r[i] <= {root_in[RW-2:0], 1'b1};
        end else begin
          rem_r[i]  <= rem_sh;
          root_r[i] <= {root_in[RW-2:0], 1'b0};
        end
      end
    end

    if (i < RW - 1) begin : g_rad
      always_ff @(posedge clk) begin
        if (en[i]) begin
          rad_r[i] <= rad_in << 2;
        end
      end
    end
  end

  logic [RW+15:0] half_ext;
  logic           sat;

  assign half_ext = {16'b0, root_r[RW-1]} >> 1;
  assign sat      = |half_ext[RW+15:MAG_W];
  assign mag      = sat ? MAG_MAX : half_ext[MAG_W-1:0];

endmodule

FILE: design/matrix_to_quaternion.sv
// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_ready     in_m_xx .. in_m_xy, nine Q1.14 entries
// out_      output     out_valid / out_ready   out_quat_w, out_quat_x, out_quat_y, out_quat_z
//
// One matrix is accepted per cycle while in_ready is high. The pipeline is a radicand register,
// W/2 square-root stages (16 at FRAC_BITS = 14), where W is the even-rounded radicand width, and
// an output register. The four square-root lanes resolve one root bit per stage.
// Reset clears all stage valid bits; payload registers are not reset.
// A stalled output holds only the unbroken run of full stages behind it; empty stages keep filling.
module matrix_to_quaternion
  import mtq_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  entry_t in_m_xx,
  input  entry_t in_m_yy,
  input  entry_t in_m_zz,
  input  entry_t in_m_zy,
  input  entry_t in_m_yz,
  input  entry_t in_m_xz,
  input  entry_t in_m_zx,
  input  entry_t in_m_yx,
  input  entry_t in_m_xy,
  output logic   out_valid,
  input  logic   out_ready,
  output mag_t   out_quat_w,
  output comp_t  out_quat_x,
  output comp_t  out_quat_y,
  output comp_t  out_quat_z
);

  localparam int SW  = ((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 3;
  localparam int VW  = SW - 1 + FRAC_BITS;
  localparam int VW2 = VW + (VW % 2);
  localparam int RW  = VW2 / 2;
  localparam int NST = RW + 2;

  logic [NST-1:0] v_r;
  logic [NST-1:0] rdy;

  always_comb begin
    rdy[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  logic signed [SW-1:0] one;
  logic signed [SW-1:0] xx, yy, zz;
  logic signed [SW-1:0] s_w, s_x, s_y, s_z;

  assign one = SW'(1) <<< FRAC_BITS;
  assign xx  = SW'(in_m_xx);
  assign yy  = SW'(in_m_yy);
  assign zz  = SW'(in_m_zz);
  assign s_w = one + xx + yy + zz;
  assign s_x = one + xx - yy - zz;
  assign s_y = one - xx + yy - zz;
  assign s_z = one - xx - yy + zz;

  function automatic logic [VW2-1:0] clamp_rad(input logic signed [SW-1:0] s);
    logic [VW2-1:0] r;
    if (s[SW-1] || s == '0) begin
      r = '0;
    end else begin
      r = VW2'(s[SW-2:0]) << FRAC_BITS;
    end
    return r;
  endfunction

  logic [VW2-1:0] rad_w_r, rad_x_r, rad_y_r, rad_z_r;
  sign_t          sgn_r [RW+1];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      rad_w_r        <= clamp_rad(s_w);
      rad_x_r        <= clamp_rad(s_x);
      rad_y_r        <= clamp_rad(s_y);
      rad_z_r        <= clamp_rad(s_z);
      sgn_r[0].neg_x <= in_m_zy > in_m_yz;
      sgn_r[0].neg_y <= in_m_xz > in_m_zx;
      sgn_r[0].neg_z <= in_m_yx > in_m_xy;
    end
    for (int k = 1; k <= RW; k++) begin
      if (rdy[k]) begin
        sgn_r[k] <= sgn_r[k-1];
      end
    end
  end

  mag_t mag_w, mag_x, mag_y, mag_z;

  mtq_sqrt_lane #(.RAD_W(VW2)) u_lane_w (
    .clk (clk), .en (rdy[RW:1]), .rad (rad_w_r), .mag (mag_w)
  );
  mtq_sqrt_lane #(.RAD_W(VW2)) u_lane_x (
    .clk (clk), .en (rdy[RW:1]), .rad (rad_x_r), .mag (mag_x)
  );
  mtq_sqrt_lane #(.RAD_W(VW2)) u_lane_y (
    .clk (clk), .en (rdy[RW:1]), .rad (rad_y_r), .mag (mag_y)
  );
  mtq_sqrt_lane #(.RAD_W(VW2)) u_lane_z (
    .clk (clk), .en (rdy[RW:1]), .rad (rad_z_r), .mag (mag_z)
  );

  function automatic comp_t apply_sign(input mag_t m, input logic neg);
    comp_t c;
    c = comp_t'({1'b0, m});
    return neg ? -c : c;
  endfunction

  mag_t  quat_w_r;
  comp_t quat_x_r, quat_y_r, quat_z_r;

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      quat_w_r <= mag_w;
      quat_x_r <= apply_sign(mag_x, sgn_r[RW].neg_x);
      quat_y_r <= apply_sign(mag_y, sgn_r[RW].neg_y);
      quat_z_r <= apply_sign(mag_z, sgn_r[RW].neg_z);
    end
  end

  assign out_quat_w = quat_w_r;
  assign out_quat_x = quat_x_r;
  assign out_quat_y = quat_y_r;
  assign out_quat_z = quat_z_r;

endmodule
